@@ hw/rtl/lcs_pkg.sv @@
// Shared types, constants and codes for the line centroid steering unit.
package lcs_pkg;

	localparam int ROW_WIDTH = 150;
	localparam int COL_W     = 8;
	localparam int CNT_W     = 8;
	localparam int SUM_W     = 14;
	localparam int WALL_W    = 7;
	localparam int SPEED_W   = 16;
	localparam int V_W       = 7;
	localparam int DIV_STEPS = SUM_W;
	localparam int DIV_CW    = $clog2(DIV_STEPS);

	localparam logic [7:0]         WHITE_MIN  = 8'd250;
	localparam logic [7:0]         WALL_RED   = 8'd255;
	localparam logic [COL_W-1:0]   COL_MAX    = {COL_W{1'b1}};
	localparam logic [CNT_W-1:0]   CNT_MAX    = {CNT_W{1'b1}};
	localparam logic [SUM_W-1:0]   SUM_MAX    = {SUM_W{1'b1}};
	localparam logic [COL_W-1:0]   WALL_LO    = 8'd1;
	localparam logic [COL_W-1:0]   WALL_HI    = 8'd75;
	localparam logic [WALL_W-1:0]  WALL_SPAN  = 7'd75;
	localparam logic [SUM_W-1:0]   HALF_ROW   = SUM_W'(ROW_WIDTH / 2);
	localparam logic [V_W-1:0]     BASE_RESET = 7'd25;
	localparam logic [SPEED_W-1:0] SPIN_RIGHT = 16'd110;
	localparam logic [SPEED_W-1:0] SPEED_MAX  = {SPEED_W{1'b1}};

	typedef enum logic [2:0] {
		MODE_FWD   = 3'd0,
		MODE_LEFT  = 3'd1,
		MODE_RIGHT = 3'd2,
		MODE_SPIN  = 3'd3,
		MODE_WALL  = 3'd4
	} mode_t;

	typedef struct packed {
		logic acc_en;
		logic row_close;
		logic div_step;
		logic mul_en;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} sts_t;

endpackage

@@ hw/rtl/line_centroid_steering_unit.sv @@
// Top level of the line centroid steering unit.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  in       | in_valid/in_stall  | red, green, blue, wall_red, row_end
//  out      | out_valid/out_stall| left_speed, right_speed, steer_mode,
//           |                    | wall_gap, line_pixels
//  cfg      | cfg_valid/cfg_ready| cfg_data (base_speed)
//
// One column beat a cycle while a row accumulates.
// After the row_end beat the input stalls through the serial divide for the
// centroid quotient, the multiply and the result load, and longer while the
// previous result beat is still held by out_stall.
// Reset clears the accumulators and sets base_speed to 25.
module line_centroid_steering_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [7:0]  wall_red,
	input  logic        row_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] left_speed,
	output logic [15:0] right_speed,
	output logic [2:0]  steer_mode,
	output logic [6:0]  wall_gap,
	output logic [7:0]  line_pixels,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data
);

	lcs_pkg::cmd_t cmd;
	lcs_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	lcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.row_end  (row_end),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	lcs_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_valid & cfg_ready),
		.cfg_data    (cfg_data),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.wall_red    (wall_red),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.left_speed  (left_speed),
		.right_speed (right_speed),
		.steer_mode  (steer_mode),
		.wall_gap    (wall_gap),
		.line_pixels (line_pixels)
	);

endmodule

@@ hw/rtl/lcs_ctrl.sv @@
// Sequencer: column accumulation, row close divide, multiply and result load.
module lcs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          row_end,
	input  lcs_pkg::sts_t sts,
	output lcs_pkg::cmd_t cmd,
	output logic          in_stall
);

	typedef enum logic [3:0] {
		ST_ACC = 4'b0001,
		ST_DIV = 4'b0010,
		ST_MUL = 4'b0100,
		ST_OUT = 4'b1000
	} state_t;

	state_t state_q, state_nx;
	logic [lcs_pkg::DIV_CW-1:0] cnt_q;
	logic div_last;

	assign div_last = (cnt_q == lcs_pkg::DIV_CW'(lcs_pkg::DIV_STEPS - 1));
	assign in_stall = (state_q != ST_ACC);

	always_comb begin
		state_nx      = state_q;
		cmd           = '0;
		case (state_q)
			ST_ACC: begin
				cmd.acc_en    = in_valid;
				cmd.row_close = in_valid & row_end;
				if (in_valid && row_end) state_nx = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_last) state_nx = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_nx   = ST_OUT;
			end
			ST_OUT: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_ACC;
				end
			end
			default: state_nx = ST_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (cmd.row_close) cnt_q <= '0;
			else if (cmd.div_step) cnt_q <= cnt_q + 1'b1;
		end
	end

`ifndef SYNTH
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !sts.out_busy)
		else $error("result loaded over a held beat");
	a_close_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.row_close |=> in_stall && cnt_q == '0)
		else $error("input not stalled after row close");
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> cnt_q < lcs_pkg::DIV_CW'(lcs_pkg::DIV_STEPS))
		else $error("divide step count overrun");
	a_mul_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_en |-> $past(cmd.div_step) && $past(div_last))
		else $error("multiply without finished divide");
`endif

endmodule

@@ hw/rtl/lcs_dp.sv @@
// Datapath: row accumulators, serial divider, speed multiply and result register.
module lcs_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lcs_pkg::cmd_t                 cmd,
	output lcs_pkg::sts_t                 sts,
	input  logic                          cfg_we,
	input  logic [lcs_pkg::V_W-1:0]       cfg_data,
	input  logic [7:0]                    red,
	input  logic [7:0]                    green,
	input  logic [7:0]                    blue,
	input  logic [7:0]                    wall_red,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lcs_pkg::SPEED_W-1:0]   left_speed,
	output logic [lcs_pkg::SPEED_W-1:0]   right_speed,
	output logic [2:0]                    steer_mode,
	output logic [lcs_pkg::WALL_W-1:0]    wall_gap,
	output logic [lcs_pkg::CNT_W-1:0]     line_pixels
);

	localparam int SW = lcs_pkg::SUM_W;
	localparam int CW = lcs_pkg::CNT_W;
	localparam int PW = lcs_pkg::V_W + 3 + SW;

	logic [lcs_pkg::V_W-1:0]    base_q;
	logic [lcs_pkg::COL_W-1:0]  col_q;
	logic [CW-1:0]              wt_q, wt_nx;
	logic [SW-1:0]              sum_q, sum_nx;
	logic [lcs_pkg::WALL_W-1:0] wcol_q, wcol_nx;
	logic                       wfound_q, wfound_nx;
	logic                       white, wall_hit;
	logic [SW:0]                sum_add;

	// row snapshot and divider
	logic [CW-1:0]              div_q;
	logic [CW-1:0]              rem_q;
	logic [SW-1:0]              quo_q;
	logic [CW:0]                trial;
	logic                       fits;
	logic [CW-1:0]              snap_wt_q;
	logic [lcs_pkg::WALL_W-1:0] snap_wcol_q;
	logic                       snap_wfound_q;

	// multiply stage
	logic [SW-1:0]              mag;
	logic                       pos, neg;
	logic [lcs_pkg::V_W+2:0]    v5;
	logic [PW-1:0]              prod_q;
	logic                       pos_q, neg_q;

	// result
	logic [PW:0]                fast_w;
	logic [lcs_pkg::SPEED_W-1:0] fast, v100, v50;
	logic [lcs_pkg::SPEED_W-1:0] left_nx, right_nx;
	lcs_pkg::mode_t             mode_nx;
	logic [lcs_pkg::WALL_W-1:0] gap_nx;
	logic                       out_valid_q;

	assign white = (red > lcs_pkg::WHITE_MIN) && (green > lcs_pkg::WHITE_MIN)
		&& (blue > lcs_pkg::WHITE_MIN);
	assign wall_hit = (col_q >= lcs_pkg::WALL_LO) && (col_q <= lcs_pkg::WALL_HI)
		&& (wall_red == lcs_pkg::WALL_RED);
	assign sum_add = {1'b0, sum_q} + (SW + 1)'(col_q);

	always_comb begin
		wt_nx     = wt_q;
		sum_nx    = sum_q;
		wcol_nx   = wcol_q;
		wfound_nx = wfound_q;
		if (white) begin
			if (wt_q != lcs_pkg::CNT_MAX) wt_nx = wt_q + 1'b1;
			sum_nx = sum_add[SW] ? lcs_pkg::SUM_MAX : sum_add[SW-1:0];
		end
		if (wall_hit) begin
			wcol_nx   = col_q[lcs_pkg::WALL_W-1:0];
			wfound_nx = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= lcs_pkg::BASE_RESET;
			col_q    <= '0;
			wt_q     <= '0;
			sum_q    <= '0;
			wcol_q   <= '0;
			wfound_q <= 1'b0;
		end else begin
			if (cfg_we) base_q <= cfg_data;
			if (cmd.row_close) begin
				col_q    <= '0;
				wt_q     <= '0;
				sum_q    <= '0;
				wcol_q   <= '0;
				wfound_q <= 1'b0;
			end else if (cmd.acc_en) begin
				if (col_q != lcs_pkg::COL_MAX) col_q <= col_q + 1'b1;
				wt_q     <= wt_nx;
				sum_q    <= sum_nx;
				wcol_q   <= wcol_nx;
				wfound_q <= wfound_nx;
			end
		end
	end

	// restoring divide, one quotient bit a beat
	assign trial = {rem_q, quo_q[SW-1]};
	assign fits  = (trial >= {1'b0, div_q});

	always_ff @(posedge clk) begin
		if (cmd.row_close) begin
			div_q         <= wt_nx;
			rem_q         <= '0;
			quo_q         <= sum_nx;
			snap_wt_q     <= wt_nx;
			snap_wcol_q   <= wcol_nx;
			snap_wfound_q <= wfound_nx;
		end else if (cmd.div_step) begin
			rem_q <= fits ? CW'(trial - {1'b0, div_q}) : trial[CW-1:0];
			quo_q <= {quo_q[SW-2:0], fits};
		end
	end

	assign pos = (quo_q < lcs_pkg::HALF_ROW);
	assign neg = (quo_q > lcs_pkg::HALF_ROW);
	assign mag = pos ? (lcs_pkg::HALF_ROW - quo_q) : (quo_q - lcs_pkg::HALF_ROW);
	assign v5  = (lcs_pkg::V_W + 3)'(base_q) * 4'd5;

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= PW'(v5) * PW'(mag);
			pos_q  <= pos;
			neg_q  <= neg;
		end
	end

	assign v100   = lcs_pkg::SPEED_W'(base_q) * 16'd100;
	assign v50    = lcs_pkg::SPEED_W'(base_q) * 16'd50;
	assign fast_w = (PW + 1)'(v100) + (PW + 1)'(prod_q);
	assign fast   = (fast_w > (PW + 1)'(lcs_pkg::SPEED_MAX)) ? lcs_pkg::SPEED_MAX
		: fast_w[lcs_pkg::SPEED_W-1:0];
	assign gap_nx = snap_wfound_q ? (lcs_pkg::WALL_SPAN - snap_wcol_q) : lcs_pkg::WALL_SPAN;

	always_comb begin
		left_nx  = '0;
		right_nx = '0;
		mode_nx  = lcs_pkg::MODE_WALL;
		if (snap_wt_q != '0) begin
			if (pos_q) begin
				left_nx  = v100;
				right_nx = fast;
				mode_nx  = lcs_pkg::MODE_LEFT;
			end else if (neg_q) begin
				left_nx  = fast;
				right_nx = v100;
				mode_nx  = lcs_pkg::MODE_RIGHT;
			end else begin
				left_nx  = v100;
				right_nx = v100;
				mode_nx  = lcs_pkg::MODE_FWD;
			end
		end else if (!snap_wfound_q) begin
			left_nx  = v50;
			right_nx = lcs_pkg::SPIN_RIGHT;
			mode_nx  = lcs_pkg::MODE_SPIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			left_speed  <= left_nx;
			right_speed <= right_nx;
			steer_mode  <= mode_nx;
			wall_gap    <= gap_nx;
			line_pixels <= snap_wt_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.out_busy = out_valid_q & out_stall;

endmodule

@@ tb/sv/line_centroid_steering_unit_test.sv @@
// Self-checking testbench for the line centroid steering unit: directed rows, then random rows.
module line_centroid_steering_unit_test;
	import lcs_pkg::*;

	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] wall_red;
		logic       row_end;
	} column_t;

	typedef struct {
		logic [15:0] left;
		logic [15:0] right;
		mode_t       mode;
		logic [6:0]  gap;
		logic [7:0]  pixels;
	} steering_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  wall_red;
	logic        row_end;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] left_speed;
	logic [15:0] right_speed;
	logic [2:0]  steer_mode;
	logic [6:0]  wall_gap;
	logic [7:0]  line_pixels;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [6:0]  cfg_data;

	steering_t expected_steering[$];
	int        error_count;
	int        sender_idle_pct;
	int        recv_stall_pct;

	// own copy of the row accumulators and speed register
	int          col_index;
	int          white_count;
	int          col_sum;
	int          wall_col;
	bit          wall_seen;
	logic [6:0]  speed_setting;

	line_centroid_steering_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.wall_red    (wall_red),
		.row_end     (row_end),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.left_speed  (left_speed),
		.right_speed (right_speed),
		.steer_mode  (steer_mode),
		.wall_gap    (wall_gap),
		.line_pixels (line_pixels),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("%0t: %s", $time, msg);
	endtask

	task automatic clear_row_state();
		col_index   = 0;
		white_count = 0;
		col_sum     = 0;
		wall_col    = 0;
		wall_seen   = 1'b0;
	endtask

	task automatic predict_steering(input column_t c);
		int        v;
		int        mean;
		int        offset;
		int        mag;
		int        fast;
		steering_t r;
		v = speed_setting;
		if (c.red > WHITE_MIN && c.green > WHITE_MIN && c.blue > WHITE_MIN) begin
			if (white_count < CNT_MAX) white_count++;
			col_sum += col_index;
			if (col_sum > SUM_MAX) col_sum = SUM_MAX;
		end
		if (col_index >= WALL_LO && col_index <= WALL_HI && c.wall_red == WALL_RED) begin
			wall_col  = col_index;
			wall_seen = 1'b1;
		end
		if (col_index < COL_MAX) col_index++;
		if (!c.row_end) return;
		r.gap    = wall_seen ? 7'(WALL_SPAN - wall_col) : WALL_SPAN;
		r.pixels = 8'(white_count);
		if (white_count > 0) begin
			mean   = col_sum / white_count;
			offset = ROW_WIDTH / 2 - mean;
			mag    = offset < 0 ? -offset : offset;
			fast   = 100 * v + 5 * v * mag;
			if (fast > SPEED_MAX) fast = SPEED_MAX;
			if (offset > 0) begin
				r.left  = 16'(100 * v);
				r.right = 16'(fast);
				r.mode  = MODE_LEFT;
			end else if (offset < 0) begin
				r.left  = 16'(fast);
				r.right = 16'(100 * v);
				r.mode  = MODE_RIGHT;
			end else begin
				r.left  = 16'(100 * v);
				r.right = 16'(100 * v);
				r.mode  = MODE_FWD;
			end
		end else if (!wall_seen) begin
			r.left  = 16'(50 * v);
			r.right = SPIN_RIGHT;
			r.mode  = MODE_SPIN;
		end else begin
			r.left  = '0;
			r.right = '0;
			r.mode  = MODE_WALL;
		end
		expected_steering.push_back(r);
		clear_row_state();
	endtask

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin : check_results
		steering_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_steering.size() == 0) begin
				report_mismatch("result beat with none expected");
			end else begin
				want = expected_steering.pop_front();
				if (left_speed !== want.left)
					report_mismatch($sformatf("left_speed got %0d want %0d",
						left_speed, want.left));
				if (right_speed !== want.right)
					report_mismatch($sformatf("right_speed got %0d want %0d",
						right_speed, want.right));
				if (steer_mode !== want.mode)
					report_mismatch($sformatf("steer_mode got %0d want %0d",
						steer_mode, want.mode));
				if (wall_gap !== want.gap)
					report_mismatch($sformatf("wall_gap got %0d want %0d",
						wall_gap, want.gap));
				if (line_pixels !== want.pixels)
					report_mismatch($sformatf("line_pixels got %0d want %0d",
						line_pixels, want.pixels));
			end
		end
	end

	task automatic send_column(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic [7:0] w, input logic last);
		column_t c;
		c = '{r, g, b, w, last};
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		red      = r;
		green    = g;
		blue     = b;
		wall_red = w;
		row_end  = last;
		do @(posedge clk); while (in_stall);
		predict_steering(c);
	endtask

	// waits for every outstanding result, then lets the block settle
	task automatic wait_drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_steering.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_base_speed(input logic [6:0] value);
		wait_drain();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = value;
		do @(posedge clk); while (!cfg_ready);
		speed_setting = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// black row with white pixels in [white_lo, white_hi] and at most one wall column
	task automatic send_plain_row(input int length, input int white_lo, input int white_hi,
			input int wall_at);
		logic [7:0] px;
		for (int col = 0; col < length; col++) begin
			px = (col >= white_lo && col <= white_hi) ? 8'd255 : 8'd0;
			send_column(px, px, px, (col == wall_at) ? WALL_RED : 8'd0, col == length - 1);
		end
	endtask

	task automatic test_spin_and_threshold();
		send_column(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		send_column(8'd250, 8'd255, 8'd255, 8'd254, 1'b0);
		send_column(8'd255, 8'd250, 8'd255, 8'd0, 1'b0);
		send_column(8'd255, 8'd255, 8'd250, 8'd255, 1'b1);
		send_column(8'd251, 8'd251, 8'd251, 8'd0, 1'b1);
		send_column(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
	endtask

	// wall at column 0 lies outside the wall window
	task automatic test_wall_only();
		send_plain_row(2, -1, -1, 1);
		send_plain_row(3, -1, -1, 0);
	endtask

	task automatic test_centroid_modes();
		send_plain_row(76, 75, 75, 75);
		send_plain_row(77, 76, 76, 10);
		send_plain_row(6, 2, 4, 3);
	endtask

	// a row past the column counter limit, then a far off-centre one: saturating count, sum and speed
	task automatic test_long_rows();
		write_base_speed(7'd100);
		send_plain_row(258, 0, 257, 40);
		send_plain_row(190, 189, 189, 76);
	endtask

	task automatic test_config_extremes();
		logic [6:0] settings[4];
		settings = '{7'd0, 7'd1, 7'd90, 7'd75};
		foreach (settings[i]) begin
			write_base_speed(settings[i]);
			send_plain_row(4, 0, 1, -1);
			send_plain_row(1, -1, -1, -1);
		end
	endtask

	task automatic send_random_row(output int length);
		int         kind;
		int         style;
		int         band_lo;
		int         band_hi;
		int         white_pct;
		int         wall_pct;
		logic [7:0] ch[3];
		logic [7:0] w;
		kind = $urandom_range(99);
		if (kind < 70) length = $urandom_range(1, 12);
		else if (kind < 92) length = $urandom_range(13, 60);
		else length = $urandom_range(61, 160);
		style   = $urandom_range(3);
		band_lo = $urandom_range(length - 1);
		band_hi = band_lo + $urandom_range(8);
		case ($urandom_range(2))
			0: wall_pct = 0;
			1: wall_pct = 5;
			default: wall_pct = 30;
		endcase
		for (int col = 0; col < length; col++) begin
			case (style)
				0: white_pct = 20;
				1: white_pct = 85;
				2: white_pct = (col >= band_lo && col <= band_hi) ? 95 : 2;
				default: white_pct = 0;
			endcase
			if ($urandom_range(99) < white_pct) begin
				foreach (ch[i]) ch[i] = 8'($urandom_range(251, 255));
			end else begin
				foreach (ch[i])
					ch[i] = ($urandom_range(99) < 30) ? 8'($urandom_range(248, 255))
						: 8'($urandom_range(255));
			end
			w = ($urandom_range(99) < wall_pct) ? WALL_RED : 8'($urandom_range(255));
			send_column(ch[0], ch[1], ch[2], w, col == length - 1);
		end
	endtask

	task automatic test_random_rows();
		int phase_items;
		int phase_rows;
		int length;
		for (int phase = 0; phase < 3; phase++) begin
			write_base_speed(7'($urandom_range(100)));
			case (phase)
				0: begin
					sender_idle_pct = 9;
					recv_stall_pct  = 52;
				end
				1: begin
					sender_idle_pct = 52;
					recv_stall_pct  = 9;
				end
				default: begin
					sender_idle_pct = 0;
					recv_stall_pct  = 0;
				end
			endcase
			phase_items = 0;
			phase_rows  = 0;
			while (phase_items < 40 || phase_rows < 4) begin
				send_random_row(length);
				phase_items += length;
				phase_rows++;
				if ($urandom_range(19) == 0) wait_drain();
			end
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		red             = '0;
		green           = '0;
		blue            = '0;
		wall_red        = '0;
		row_end         = 1'b0;
		out_stall       = 1'b0;
		cfg_valid       = 1'b0;
		cfg_data        = '0;
		error_count     = 0;
		sender_idle_pct = 9;
		recv_stall_pct  = 52;
		speed_setting   = BASE_RESET;
		clear_row_state();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_spin_and_threshold();
		test_wall_only();
		test_centroid_modes();
		test_long_rows();
		test_config_extremes();
		test_random_rows();

		wait_drain();
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
